### rtl/core/bga_pkg.sv
// Shared types, constants and helper functions of the boost group aggregator.
package bga_pkg;

    // Field widths of the input and result beats.
    localparam int ACTION_W  = 3;
    localparam int GROUP_W   = 2;
    localparam int UTIL_W    = 11;
    localparam int TIME_W    = 64;
    localparam int BOOST_W   = 7;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Width of the headroom times wakeup boost product (2047 * 100 fits in 18 bits).
    localparam int PROD_W = 18;

    // Division by 100 as multiply by 335545 and shift right by 25, exact below 2^18.
    localparam int                   DIV_MUL_W    = 19;
    localparam logic [DIV_MUL_W-1:0] DIV100_MUL   = 19'd335545;
    localparam int                   DIV100_SHIFT = 25;
    localparam int                   SCALE_W      = PROD_W + DIV_MUL_W;

    // Boost limits and register reset values.
    localparam logic [BOOST_W-1:0] BOOST_CAP     = 7'd100;
    localparam logic [UTIL_W-1:0]  VIP_RESET     = 11'd50;
    localparam logic [UTIL_W-1:0]  CAP_RESET     = 11'd1024;
    localparam logic [WORD_W-1:0]  HOLD_RESET    = 32'd50000000;
    localparam int                 TABLE_GROUPS  = 4;

    // Event codes carried in the action field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 3'd0,
        ACT_DEQUEUE = 3'd1,
        ACT_MOVE    = 3'd2,
        ACT_BOOST   = 3'd3,
        ACT_WAKEUP  = 3'd4
    } t_action;

    // Result kinds.
    localparam logic KIND_BOOST  = 1'b0;
    localparam logic KIND_WAKEUP = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_BOOST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_BOOST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIP_THRESH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_CAP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME   = 3'd4;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [WORD_W-1:0] group_boost;
        logic [WORD_W-1:0] wake_boost;
        logic [UTIL_W-1:0] wake_thresh;
        logic [UTIL_W-1:0] cpu_capacity;
        logic [WORD_W-1:0] hold_time;
    } t_cfg;

    // One registered input beat.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [GROUP_W-1:0]  group_index;
        logic [GROUP_W-1:0]  dest_group;
        logic                is_wakeup;
        logic                is_realtime;
        logic [UTIL_W-1:0]   task_util;
        logic [TIME_W-1:0]   now_ns;
    } t_item;

    // Partial result handed from the engine to the margin stage.
    typedef struct packed {
        logic               kind;
        logic [BOOST_W-1:0] boost;
        logic [UTIL_W-1:0]  util;
        logic [PROD_W-1:0]  prod;
    } t_mid;

    // Signed boost byte of a group; groups past the table have no boost.
    function automatic logic signed [8:0] group_boost(logic [WORD_W-1:0] tbl, int g);
        logic [7:0] byte_v;
        byte_v = '0;
        if (g >= TABLE_GROUPS) begin
            return '0;
        end
        byte_v = tbl[8*g +: 8];
        return {byte_v[7], byte_v};
    endfunction

    // Wakeup boost of a group, saturated at 100.
    function automatic logic [BOOST_W-1:0] wake_boost(logic [WORD_W-1:0] tbl, int g);
        logic [7:0] byte_v;
        byte_v = '0;
        if (g >= TABLE_GROUPS) begin
            return '0;
        end
        byte_v = tbl[8*g +: 8];
        return (byte_v > 8'd100) ? BOOST_CAP : byte_v[BOOST_W-1:0];
    endfunction

    // A stamp has expired once more than the hold time has passed, with wraparound.
    function automatic logic hold_expired(logic [TIME_W-1:0] now, logic [TIME_W-1:0] ts,
                                          logic [WORD_W-1:0] hold);
        logic [TIME_W-1:0] delta;
        delta = now - ts;
        return delta > {{(TIME_W-WORD_W){1'b0}}, hold};
    endfunction

    // Clamp a signed boost into 0 to 100.
    function automatic logic [BOOST_W-1:0] clamp_boost(logic signed [8:0] v);
        if (v < 9'sd0) begin
            return '0;
        end
        if (v > 9'sd100) begin
            return BOOST_CAP;
        end
        return v[BOOST_W-1:0];
    endfunction

endpackage

### rtl/core/bga_if.sv
// Valid/ready channel interfaces for input events, results and configuration writes.
interface bga_in_if;
    import bga_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [GROUP_W-1:0]  group_index;
    logic [GROUP_W-1:0]  dest_group;
    logic                is_wakeup;
    logic                is_realtime;
    logic [UTIL_W-1:0]   task_util;
    logic [TIME_W-1:0]   now_ns;

    modport source (output valid, action, group_index, dest_group, is_wakeup, is_realtime,
                    task_util, now_ns, input ready);
    modport sink   (input valid, action, group_index, dest_group, is_wakeup, is_realtime,
                    task_util, now_ns, output ready);
endinterface

interface bga_out_if;
    import bga_pkg::*;

    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [BOOST_W-1:0] eff_boost;
    logic [UTIL_W-1:0]  wake_util;

    modport source (output valid, result_kind, eff_boost, wake_util, input ready);
    modport sink   (input valid, result_kind, eff_boost, wake_util, output ready);
endinterface

interface bga_cfg_if;
    import bga_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bga_cfg_regs.sv
// Configuration register file of the boost group aggregator.
module bga_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bga_cfg_if.sink       i_cfg,
    output bga_pkg::t_cfg o_cfg
);
    import bga_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; indexes past the list are dropped.
    assign i_cfg.ready = 1'b1;

    // Decode one write beat into the selected register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GROUP_BOOST: n_cfg.group_boost  = i_cfg.data;
                REG_WAKE_BOOST:  n_cfg.wake_boost   = i_cfg.data;
                REG_VIP_THRESH:  n_cfg.wake_thresh  = i_cfg.data[UTIL_W-1:0];
                REG_CPU_CAP:     n_cfg.cpu_capacity = i_cfg.data[UTIL_W-1:0];
                REG_HOLD_TIME:   n_cfg.hold_time    = i_cfg.data;
                default: ;
            endcase
        end
    end

    // Registers with their reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.group_boost  <= '0;
            r_cfg.wake_boost   <= '0;
            r_cfg.wake_thresh  <= VIP_RESET;
            r_cfg.cpu_capacity <= CAP_RESET;
            r_cfg.hold_time    <= HOLD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/bga_engine.sv
// Group state and single-pass event evaluation of the boost group aggregator.
module bga_engine #(
    parameter int NUM_GROUPS = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bga_pkg::t_cfg  i_cfg,
    input  bga_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_take,
    input  logic           i_mid_ready,
    output bga_pkg::t_mid  o_mid,
    output logic           o_mid_valid
);
    import bga_pkg::*;

    typedef logic [COUNT_BITS-1:0] t_count;

    t_count             r_task   [NUM_GROUPS];
    t_count             n_task   [NUM_GROUPS];
    t_count             r_woken  [NUM_GROUPS];
    t_count             n_woken  [NUM_GROUPS];
    logic [TIME_W-1:0]  r_gstamp [NUM_GROUPS];
    logic [TIME_W-1:0]  n_gstamp [NUM_GROUPS];
    logic [BOOST_W-1:0] r_cur_boost;
    logic [BOOST_W-1:0] n_cur_boost;
    logic [TIME_W-1:0]  r_bstamp;
    logic [TIME_W-1:0]  n_bstamp;
    t_mid               r_mid;
    t_mid               n_mid;
    logic               r_mid_valid;
    logic               n_mid_valid;
    logic               w_adv;
    logic               w_fire;

    function automatic t_count count_inc(t_count c);
        return (&c) ? c : c + t_count'(1);
    endfunction

    function automatic t_count count_dec(t_count c);
        return (c == '0) ? c : c - t_count'(1);
    endfunction

    // The partial result register moves on when empty or drained.
    assign w_adv  = !r_mid_valid || i_mid_ready;
    assign w_fire = i_item_valid && w_adv;
    assign o_take = w_adv;

    // Event evaluation: counts and stamps first, then the boost re-evaluation.
    always_comb begin
        logic               src_ok;
        logic               dst_ok;
        logic               reeval;
        logic               active;
        logic signed [8:0]  best;
        logic signed [8:0]  b;
        logic [TIME_W-1:0]  stamp;
        logic [BOOST_W-1:0] wb;
        logic [BOOST_W-1:0] wbg;
        logic [UTIL_W-1:0]  diff;

        src_ok = int'(i_item.group_index) < NUM_GROUPS;
        dst_ok = int'(i_item.dest_group) < NUM_GROUPS;
        reeval = 1'b0;
        wb     = '0;
        wbg    = '0;
        diff   = i_cfg.cpu_capacity - i_item.task_util;

        n_task      = r_task;
        n_woken     = r_woken;
        n_gstamp    = r_gstamp;
        n_cur_boost = r_cur_boost;
        n_bstamp    = r_bstamp;
        n_mid       = r_mid;
        n_mid_valid = r_mid_valid && !i_mid_ready;

        if (w_fire) begin
            case (i_item.action)
                ACT_ENQUEUE: begin
                    for (int g = 0; g < NUM_GROUPS; g++) begin
                        if (g == int'(i_item.group_index)) begin
                            n_task[g] = count_inc(r_task[g]);
                            if (i_item.is_wakeup && i_item.task_util >= i_cfg.wake_thresh) begin
                                n_woken[g] = count_inc(r_woken[g]);
                            end
                            if (i_item.is_realtime) begin
                                n_gstamp[g] = i_item.now_ns;
                            end
                            reeval = (n_task[g] == t_count'(1));
                        end
                    end
                end
                ACT_DEQUEUE: begin
                    for (int g = 0; g < NUM_GROUPS; g++) begin
                        if (g == int'(i_item.group_index)) begin
                            n_task[g] = count_dec(r_task[g]);
                        end
                    end
                end
                ACT_MOVE: begin
                    if (src_ok && dst_ok && i_item.group_index != i_item.dest_group) begin
                        for (int g = 0; g < NUM_GROUPS; g++) begin
                            if (g == int'(i_item.group_index)) begin
                                n_task[g] = count_dec(r_task[g]);
                            end
                            if (g == int'(i_item.dest_group)) begin
                                n_task[g]   = count_inc(r_task[g]);
                                n_gstamp[g] = i_item.now_ns;
                            end
                        end
                        n_bstamp = i_item.now_ns
                                   - {{(TIME_W-WORD_W){1'b0}}, i_cfg.hold_time};
                    end
                end
                ACT_BOOST: begin
                    reeval      = hold_expired(i_item.now_ns, r_bstamp, i_cfg.hold_time);
                    n_mid.kind  = KIND_BOOST;
                    n_mid.util  = '0;
                    n_mid.prod  = '0;
                    n_mid_valid = 1'b1;
                end
                ACT_WAKEUP: begin
                    for (int g = 0; g < NUM_GROUPS; g++) begin
                        wbg = wake_boost(i_cfg.wake_boost, g);
                        if (r_woken[g] != '0 && wbg > wb) begin
                            wb = wbg;
                        end
                        n_woken[g] = '0;
                    end
                    n_mid.kind  = KIND_WAKEUP;
                    n_mid.boost = '0;
                    n_mid.util  = i_item.task_util;
                    n_mid.prod  = (i_item.task_util <= i_cfg.cpu_capacity)
                                  ? PROD_W'(diff) * PROD_W'(wb) : '0;
                    n_mid_valid = 1'b1;
                end
                default: ;
            endcase
        end

        // Largest boost among active groups; group 0 always counts, ties go later.
        best  = group_boost(i_cfg.group_boost, 0);
        stamp = i_item.now_ns;
        for (int g = 1; g < NUM_GROUPS; g++) begin
            active = (n_task[g] != '0)
                     || !hold_expired(i_item.now_ns, n_gstamp[g], i_cfg.hold_time);
            b      = group_boost(i_cfg.group_boost, g);
            if (active && b >= best) begin
                best  = b;
                stamp = n_gstamp[g];
            end
        end
        if (reeval) begin
            n_cur_boost = clamp_boost(best);
            n_bstamp    = stamp;
        end
        if (w_fire && i_item.action == ACT_BOOST) begin
            n_mid.boost = n_cur_boost;
        end
    end

    // Group state and partial result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task      <= '{default: '0};
            r_woken     <= '{default: '0};
            r_gstamp    <= '{default: '0};
            r_cur_boost <= '0;
            r_bstamp    <= '0;
            r_mid_valid <= 1'b0;
        end else begin
            r_task      <= n_task;
            r_woken     <= n_woken;
            r_gstamp    <= n_gstamp;
            r_cur_boost <= n_cur_boost;
            r_bstamp    <= n_bstamp;
            r_mid_valid <= n_mid_valid;
        end
        r_mid <= n_mid;
    end

    assign o_mid       = r_mid;
    assign o_mid_valid = r_mid_valid;

`ifndef SYNTHESIS
    // The cached boost never leaves the clamp range.
    a_boost_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_boost <= BOOST_CAP)
        else $error("cached boost above the clamp limit");

    // A boost query reports the cached boost it has just settled.
    a_boost_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_item.action == ACT_BOOST
        |=> r_mid_valid && r_mid.kind == KIND_BOOST && r_mid.boost == r_cur_boost)
        else $error("boost answer differs from the cached boost");

    // A wakeup query yields a wakeup answer with no boost field.
    a_wake_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_item.action == ACT_WAKEUP
        |=> r_mid_valid && r_mid.kind == KIND_WAKEUP && r_mid.boost == '0)
        else $error("wakeup answer malformed");
`endif

endmodule

### rtl/core/bga_margin.sv
// Margin scaling by 1/100 and result register of the boost group aggregator.
module bga_margin (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bga_pkg::t_mid i_mid,
    input  logic          i_mid_valid,
    output logic          o_mid_ready,
    bga_out_if.source     o_out
);
    import bga_pkg::*;

    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_kind;
    logic [BOOST_W-1:0] r_boost;
    logic [UTIL_W-1:0]  r_util;
    logic [SCALE_W-1:0] w_scaled;
    logic [UTIL_W-1:0]  w_quot;
    logic               w_load;

    // The result register takes a new beat once it is empty or being read.
    assign o_mid_ready = !r_out_valid || o_out.ready;
    assign w_load      = i_mid_valid && o_mid_ready;

    // Headroom product divided by 100 through the reciprocal.
    assign w_scaled = SCALE_W'(i_mid.prod) * SCALE_W'(DIV100_MUL);
    assign w_quot   = UTIL_W'(w_scaled >> DIV100_SHIFT);

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (w_load) begin
            r_kind  <= i_mid.kind;
            r_boost <= i_mid.boost;
            r_util  <= i_mid.util + w_quot;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_kind;
    assign o_out.eff_boost   = r_boost;
    assign o_out.wake_util   = r_util;

`ifndef SYNTHESIS
    // A boost answer leaves the utilization field at zero.
    a_boost_util_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && i_mid.kind == KIND_BOOST |=> r_out_valid && r_util == '0)
        else $error("boost answer carries a utilization");

    // A wakeup answer never reports less than the utilization it was given.
    a_wake_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && i_mid.kind == KIND_WAKEUP |=> r_util >= $past(i_mid.util))
        else $error("boosted utilization wrapped");

    // A wakeup answer leaves the boost field at zero.
    a_wake_boost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == KIND_WAKEUP |-> r_boost == '0)
        else $error("wakeup answer carries a boost");
`endif

endmodule

### rtl/core/boost_group_aggregator.sv
// Top level of the boost group aggregator: input register, config, engine and result stage.
//
//  Channel | Direction | Beat carries
//  --------+-----------+--------------------------------------------------------------
//  i_in    | sink      | action, group_index, dest_group, is_wakeup, is_realtime,
//          |           | task_util, now_ns
//  o_out   | source    | result_kind, eff_boost, wake_util
//  i_cfg   | sink      | index, data (always ready)
//
// One event is taken per cycle while the stages ahead are not stalled. A query answer
// reaches the result register through the input register, then the engine, which writes
// the partial result with the group state and product, then the scaling by 1/100.
// Reset is synchronous and active low; it clears all counts and stamps and loads the
// register reset values.
// When o_out stalls the three stages fill up, and i_in.ready drops only when all are full.
module boost_group_aggregator #(
    parameter int NUM_GROUPS = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bga_in_if.sink    i_in,
    bga_out_if.source o_out,
    bga_cfg_if.sink   i_cfg
);
    import bga_pkg::*;

    t_cfg  w_cfg;
    t_item r_in;
    logic  r_in_valid;
    logic  w_take;
    t_mid  w_mid;
    logic  w_mid_valid;
    logic  w_mid_ready;

    // Input register refills when empty or when the engine takes its beat.
    assign i_in.ready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in.action      <= i_in.action;
            r_in.group_index <= i_in.group_index;
            r_in.dest_group  <= i_in.dest_group;
            r_in.is_wakeup   <= i_in.is_wakeup;
            r_in.is_realtime <= i_in.is_realtime;
            r_in.task_util   <= i_in.task_util;
            r_in.now_ns      <= i_in.now_ns;
        end
    end

    // Configuration registers.
    bga_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Group state and event evaluation.
    bga_engine #(
        .NUM_GROUPS (NUM_GROUPS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item       (r_in),
        .i_item_valid (r_in_valid),
        .o_take       (w_take),
        .i_mid_ready  (w_mid_ready),
        .o_mid        (w_mid),
        .o_mid_valid  (w_mid_valid)
    );

    // Margin scaling and result register.
    bga_margin u_margin (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid       (w_mid),
        .i_mid_valid (w_mid_valid),
        .o_mid_ready (w_mid_ready),
        .o_out       (o_out)
    );

endmodule

### dv/tb.sv
// Self-checking testbench for the boost group aggregator with an event-level predictor.
module tb;
    import bga_pkg::*;

    localparam int GROUPS          = 4;
    localparam int COUNT_W         = 16;
    localparam int PCT_SCALE       = 100;
    localparam int UTIL_MAX        = 1024;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLDOFF_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_EVENTS   = 180;
    localparam int STACK_EVENTS    = 40;

    // One answer beat as the predictor expects it.
    typedef struct packed {
        logic               kind;
        logic [BOOST_W-1:0] boost;
        logic [UTIL_W-1:0]  util;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    bga_in_if  in_if ();
    bga_out_if out_if ();
    bga_cfg_if cfg_if ();

    boost_group_aggregator #(
        .NUM_GROUPS (GROUPS),
        .COUNT_BITS (COUNT_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Events waiting to be driven and answers waiting to come back.
    t_item   event_q[$];
    t_answer answer_q[$];
    t_item   drive_beat;
    t_item   seen_beat;
    t_answer got_answer;
    t_answer want_answer;

    int error_count = 0;
    int send_idle_pct;
    int sink_stall_pct;
    int holdoff_req;
    int holdoff_seen;
    int holdoff_left;
    int quiet_cycles;

    // Time base and register values the event generator plans around.
    logic [TIME_W-1:0] clock_ns;
    logic [WORD_W-1:0] plan_hold;
    logic [UTIL_W-1:0] plan_vip;

    // Predictor copy of the registers and of the group state.
    logic [WORD_W-1:0]  m_group_boost;
    logic [WORD_W-1:0]  m_wake_boost;
    logic [UTIL_W-1:0]  m_vip;
    logic [UTIL_W-1:0]  m_cap;
    logic [WORD_W-1:0]  m_hold;
    logic [COUNT_W-1:0] m_tasks[GROUPS];
    logic [COUNT_W-1:0] m_woken[GROUPS];
    logic [TIME_W-1:0]  m_stamp[GROUPS];
    logic [BOOST_W-1:0] m_boost;
    logic [TIME_W-1:0]  m_boost_stamp;

    task automatic report_mismatch(string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic void clear_model();
        m_group_boost = '0;
        m_wake_boost  = '0;
        m_vip         = VIP_RESET;
        m_cap         = CAP_RESET;
        m_hold        = HOLD_RESET;
        for (int g = 0; g < GROUPS; g++) begin
            m_tasks[g] = '0;
            m_woken[g] = '0;
            m_stamp[g] = '0;
        end
        m_boost       = '0;
        m_boost_stamp = '0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        case (idx)
            REG_GROUP_BOOST: m_group_boost = val;
            REG_WAKE_BOOST:  m_wake_boost  = val;
            REG_VIP_THRESH:  m_vip         = val[UTIL_W-1:0];
            REG_CPU_CAP:     m_cap         = val[UTIL_W-1:0];
            REG_HOLD_TIME:   m_hold        = val;
            default: ;
        endcase
    endfunction

    // A stamp is stale once strictly more than the hold time has passed, modulo 2^64.
    function automatic logic is_stale(logic [TIME_W-1:0] now, logic [TIME_W-1:0] ts);
        logic [TIME_W-1:0] gap;
        gap = now - ts;
        return gap > {{(TIME_W-WORD_W){1'b0}}, m_hold};
    endfunction

    function automatic int signed_boost(int g);
        int v;
        v = int'(m_group_boost[8*g +: 8]);
        if (v >= 128) v -= 256;
        return v;
    endfunction

    function automatic int wake_pct(int g);
        int v;
        v = int'(m_wake_boost[8*g +: 8]);
        return (v > PCT_SCALE) ? PCT_SCALE : v;
    endfunction

    function automatic logic [COUNT_W-1:0] count_up(logic [COUNT_W-1:0] c);
        return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [COUNT_W-1:0] count_down(logic [COUNT_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    // Pick the largest boost among active groups; group 0 always counts, ties go to the later.
    function automatic void refresh_boost(logic [TIME_W-1:0] now);
        int                best;
        int                b;
        logic [TIME_W-1:0] stamp;
        best  = signed_boost(0);
        stamp = now;
        for (int g = 1; g < GROUPS; g++) begin
            if (m_tasks[g] == '0 && is_stale(now, m_stamp[g])) continue;
            b = signed_boost(g);
            if (best > b) continue;
            best  = b;
            stamp = m_stamp[g];
        end
        if (best < 0) best = 0;
        if (best > PCT_SCALE) best = PCT_SCALE;
        m_boost       = best[BOOST_W-1:0];
        m_boost_stamp = stamp;
    endfunction

    // Update the predicted state for one accepted event and queue its answer, if any.
    function automatic void predict_event(t_item ev);
        t_answer ans;
        int      g;
        int      d;
        int      wb;
        int      pct;
        int      cap;
        int      util;
        int      margin;
        int      sum;
        ans = '0;
        g   = int'(ev.group_index);
        d   = int'(ev.dest_group);
        case (ev.action)
            ACT_ENQUEUE: begin
                m_tasks[g] = count_up(m_tasks[g]);
                if (ev.is_wakeup && ev.task_util >= m_vip) m_woken[g] = count_up(m_woken[g]);
                if (ev.is_realtime) m_stamp[g] = ev.now_ns;
                if (m_tasks[g] == COUNT_W'(1)) refresh_boost(ev.now_ns);
            end
            ACT_DEQUEUE: begin
                m_tasks[g] = count_down(m_tasks[g]);
            end
            ACT_MOVE: begin
                if (g != d) begin
                    m_tasks[g]    = count_down(m_tasks[g]);
                    m_tasks[d]    = count_up(m_tasks[d]);
                    m_stamp[d]    = ev.now_ns;
                    m_boost_stamp = ev.now_ns - {{(TIME_W-WORD_W){1'b0}}, m_hold};
                end
            end
            ACT_BOOST: begin
                if (is_stale(ev.now_ns, m_boost_stamp)) refresh_boost(ev.now_ns);
                ans.kind  = KIND_BOOST;
                ans.boost = m_boost;
                answer_q.push_back(ans);
            end
            ACT_WAKEUP: begin
                wb = 0;
                for (int k = 0; k < GROUPS; k++) begin
                    if (m_woken[k] != '0) begin
                        pct = wake_pct(k);
                        if (pct > wb) wb = pct;
                        m_woken[k] = '0;
                    end
                end
                cap    = int'(m_cap);
                util   = int'(ev.task_util);
                margin = (util <= cap) ? ((cap - util) * wb) / PCT_SCALE : 0;
                sum    = util + margin;
                ans.kind = KIND_WAKEUP;
                ans.util = sum[UTIL_W-1:0];
                answer_q.push_back(ans);
            end
            default: ;
        endcase
    endfunction

    // Random event with a forward-moving clock; a tenth of the events are noise.
    function automatic t_item make_event();
        t_item             ev;
        logic [TIME_W-1:0] step;
        int                pick;
        ev = '0;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: step = TIME_W'($urandom_range(plan_hold / 4))
                                     + TIME_W'($urandom_range(3));
            6, 7, 8:          step = TIME_W'(plan_hold) + TIME_W'($urandom_range(2));
            default:          step = TIME_W'({plan_hold, 1'b0});
        endcase
        clock_ns = clock_ns + step;
        pick = $urandom_range(99);
        if (pick < 30)      ev.action = ACT_ENQUEUE;
        else if (pick < 52) ev.action = ACT_DEQUEUE;
        else if (pick < 64) ev.action = ACT_MOVE;
        else if (pick < 84) ev.action = ACT_BOOST;
        else                ev.action = ACT_WAKEUP;
        ev.group_index = GROUP_W'($urandom_range(GROUPS - 1));
        ev.dest_group  = GROUP_W'($urandom_range(GROUPS - 1));
        ev.is_wakeup   = 1'($urandom_range(1));
        ev.is_realtime = 1'($urandom_range(1));
        ev.task_util   = ($urandom_range(3) == 0) ? plan_vip
                                                  : UTIL_W'($urandom_range(UTIL_MAX));
        ev.now_ns      = clock_ns;
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
                0:       ev.now_ns = {$urandom, $urandom};
                1:       ev.action = ACTION_W'($urandom_range(ACT_WAKEUP + 1,
                                                              (1 << ACTION_W) - 1));
                default: ev.task_util = $urandom_range(1) ? UTIL_W'(UTIL_MAX) : '0;
            endcase
        end
        return ev;
    endfunction

    // Byte table that favors the extremes and repeated values, so ties show up.
    function automatic logic [WORD_W-1:0] pick_table();
        logic [WORD_W-1:0] tbl;
        for (int g = 0; g < TABLE_GROUPS; g++) begin
            case ($urandom_range(5))
                0:       tbl[8*g +: 8] = 8'h80;
                1:       tbl[8*g +: 8] = 8'h9C;
                2:       tbl[8*g +: 8] = 8'h00;
                3:       tbl[8*g +: 8] = 8'd100;
                4:       tbl[8*g +: 8] = $urandom_range(1) ? 8'h7F : 8'hFF;
                default: tbl[8*g +: 8] = 8'($urandom_range(255));
            endcase
        end
        return tbl;
    endfunction

    task automatic queue_event(logic [ACTION_W-1:0] act, logic [GROUP_W-1:0] grp,
                               logic [GROUP_W-1:0] dst, logic wake, logic rt,
                               logic [UTIL_W-1:0] util, logic [TIME_W-1:0] now);
        t_item ev;
        ev.action      = act;
        ev.group_index = grp;
        ev.dest_group  = dst;
        ev.is_wakeup   = wake;
        ev.is_realtime = rt;
        ev.task_util   = util;
        ev.now_ns      = now;
        event_q.push_back(ev);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_regs(logic [WORD_W-1:0] gb, logic [WORD_W-1:0] wb,
                            logic [UTIL_W-1:0] vip, logic [UTIL_W-1:0] cap,
                            logic [WORD_W-1:0] hold);
        write_reg(REG_GROUP_BOOST, gb);
        write_reg(REG_WAKE_BOOST, wb);
        write_reg(REG_VIP_THRESH, {{(WORD_W-UTIL_W){1'b0}}, vip});
        write_reg(REG_CPU_CAP, {{(WORD_W-UTIL_W){1'b0}}, cap});
        write_reg(REG_HOLD_TIME, hold);
        plan_hold = hold;
        plan_vip  = vip;
    endtask

    // Wait until every event is in and every answer is out, then let the pipeline drain.
    task automatic settle();
        do @(negedge i_clk);
        while (event_q.size() != 0 || in_if.valid || answer_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(int src_idle, int snk_stall, logic holdoff);
        @(negedge i_clk);
        send_idle_pct  = src_idle;
        sink_stall_pct = snk_stall;
        repeat (RANDOM_EVENTS) event_q.push_back(make_event());
        if (holdoff) begin
            @(posedge i_clk);
            holdoff_req <= holdoff_req + 1;
        end
        settle();
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Event driver: holds a beat until it is taken, then offers the next one or idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_beat = event_q.pop_front();
                in_if.valid       <= 1'b1;
                in_if.action      <= drive_beat.action;
                in_if.group_index <= drive_beat.group_index;
                in_if.dest_group  <= drive_beat.dest_group;
                in_if.is_wakeup   <= drive_beat.is_wakeup;
                in_if.is_realtime <= drive_beat.is_realtime;
                in_if.task_util   <= drive_beat.task_util;
                in_if.now_ns      <= drive_beat.now_ns;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Answer sink: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            holdoff_seen <= 0;
            holdoff_left <= 0;
        end else if (holdoff_seen != holdoff_req) begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            out_if.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor: mirrors register writes, predicts each accepted event and checks each answer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready) begin
                seen_beat.action      = in_if.action;
                seen_beat.group_index = in_if.group_index;
                seen_beat.dest_group  = in_if.dest_group;
                seen_beat.is_wakeup   = in_if.is_wakeup;
                seen_beat.is_realtime = in_if.is_realtime;
                seen_beat.task_util   = in_if.task_util;
                seen_beat.now_ns      = in_if.now_ns;
                predict_event(seen_beat);
            end
            if (out_if.valid && out_if.ready) begin
                got_answer.kind  = out_if.result_kind;
                got_answer.boost = out_if.eff_boost;
                got_answer.util  = out_if.wake_util;
                if (answer_q.size() == 0) begin
                    report_mismatch("result beat with no answer pending");
                end else begin
                    want_answer = answer_q.pop_front();
                    if (got_answer.kind != want_answer.kind)
                        report_mismatch($sformatf("result_kind %0d, want %0d",
                                                  got_answer.kind, want_answer.kind));
                    if (got_answer.boost != want_answer.boost)
                        report_mismatch($sformatf("eff_boost %0d, want %0d",
                                                  got_answer.boost, want_answer.boost));
                    if (got_answer.util != want_answer.util)
                        report_mismatch($sformatf("wake_util %0d, want %0d",
                                                  got_answer.util, want_answer.util));
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat on any channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n            = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        send_idle_pct      = 0;
        sink_stall_pct     = 0;
        holdoff_req        = 0;
        clock_ns           = 64'd5000;
        plan_hold          = HOLD_RESET;
        plan_vip           = VIP_RESET;
        clear_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: signed and clamped boosts, hold edges, same-group move, margins.
        set_regs(32'h807F28FB, 32'h64C83200, 11'd50, 11'd1024, 32'd1000);
        @(negedge i_clk);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd2000);
        queue_event(ACT_DEQUEUE, 1, 0, 0, 0, 0,    64'd2000);
        queue_event(ACT_ENQUEUE, 1, 0, 1, 1, 1024, 64'd2010);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd2020);
        queue_event(ACT_ENQUEUE, 2, 0, 1, 0, 49,   64'd2030);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd2040);
        queue_event(ACT_ENQUEUE, 3, 0, 1, 1, 50,   64'd2050);
        queue_event(ACT_MOVE,    2, 2, 0, 0, 0,    64'd2060);
        queue_event(ACT_MOVE,    2, 0, 0, 0, 0,    64'd3000);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd3000);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd3001);
        queue_event(ACT_WAKEUP,  0, 0, 0, 0, 0,    64'd3010);
        queue_event(ACT_WAKEUP,  0, 0, 0, 0, 500,  64'd3020);
        queue_event(ACT_ENQUEUE, 1, 0, 1, 0, 1024, 64'd3030);
        queue_event(ACT_WAKEUP,  0, 0, 0, 0, 1024, 64'd3040);
        for (int a = ACT_WAKEUP + 1; a < (1 << ACTION_W); a++)
            queue_event(ACTION_W'(a), 1, 2, 1, 1, 1024, 64'd3050);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'hFFFF_FFFF_FFFF_FFFF);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd0);
        settle();

        // Directed: equal boosts everywhere, zero hold, zero threshold and zero capacity.
        set_regs(32'h1E1E1E1E, 32'hFFFFFFFF, 11'd0, 11'd0, 32'd0);
        @(negedge i_clk);
        queue_event(ACT_ENQUEUE, 1, 0, 1, 0, 0,    64'd10);
        queue_event(ACT_ENQUEUE, 2, 0, 1, 1, 0,    64'd10);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd10);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd11);
        queue_event(ACT_WAKEUP,  0, 0, 0, 0, 0,    64'd12);
        queue_event(ACT_WAKEUP,  0, 0, 0, 0, 1024, 64'd13);
        queue_event(ACT_DEQUEUE, 3, 0, 0, 0, 0,    64'd14);
        queue_event(ACT_DEQUEUE, 3, 0, 0, 0, 0,    64'd15);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,    64'd16);
        settle();

        // Random phases, each under its own register setting and idling pattern.
        set_regs(pick_table(), pick_table(), UTIL_W'($urandom_range(UTIL_MAX)), 11'd1024,
                 32'd5000);
        run_random(0, 0, 1'b0);
        set_regs(pick_table(), pick_table(), 11'd1024, UTIL_W'($urandom_range(UTIL_MAX)),
                 32'd0);
        run_random(72, 0, 1'b0);
        set_regs(pick_table(), pick_table(), 11'd0, 11'd0, 32'hFFFFFFFF);
        run_random(0, 72, 1'b1);
        clock_ns = 64'hFFFF_FFFF_FFFE_0000;
        set_regs(pick_table(), pick_table(), UTIL_W'($urandom_range(UTIL_MAX)),
                 UTIL_W'($urandom_range(UTIL_MAX)), $urandom_range(1, 20000));
        run_random(20, 20, 1'b0);

        // Stack many tasks and woken tasks on one group, then query and back off.
        set_regs(pick_table(), 32'h64646464, 11'd1024, 11'd1024, 32'd1000);
        @(negedge i_clk);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        repeat (STACK_EVENTS) queue_event(ACT_ENQUEUE, 3, 0, 1, 0, 1024, clock_ns);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,   clock_ns + 64'd5000);
        queue_event(ACT_WAKEUP,  0, 0, 0, 0, 100, clock_ns + 64'd5001);
        queue_event(ACT_DEQUEUE, 3, 0, 0, 0, 0,   clock_ns + 64'd5002);
        queue_event(ACT_DEQUEUE, 3, 0, 0, 0, 0,   clock_ns + 64'd5003);
        queue_event(ACT_BOOST,   0, 0, 0, 0, 0,   clock_ns + 64'd9000);
        settle();

        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
